// ===== rtl/core/ars_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_pkg
// Shared types and constants of the ADC request sequencer.
// ----------------------------------------------------------------------------
package ars_pkg;

  localparam int CHANNELS_DEF = 16;

  // Stream widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;
  localparam int TUSER_W    = 2;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_DIVIDER_MODE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIME_SELECT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MUX_PRESENT   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_TICKS = 2'd3;

  localparam logic [2:0]  TIME_SELECT_RST   = 3'd2;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1060;

  // Conversion constants
  localparam int READING_W = 28;
  localparam int PRODUCT_W = 26;
  localparam logic [9:0] CONV_SCALE = 10'd1000;
  localparam logic signed [READING_W-1:0] CODE_BASE      = 28'sd9216000;
  localparam logic signed [READING_W-1:0] OVERLOAD_VALUE = 28'sd100000000;
  localparam logic signed [READING_W-1:0] DIV16_BIAS     = 28'sd15;

  typedef enum logic [1:0] {
    REQ_CHANNEL = 2'd0,
    REQ_DONE    = 2'd1,
    REQ_TICK    = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    KIND_READING = 2'd0,
    KIND_REJECT  = 2'd1,
    KIND_START   = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EMIT_REJ,
    ST_EMIT_ST,
    ST_MUL,
    ST_SUB,
    ST_EMIT_RD,
    ST_SCAN
  } ars_state_t;

  typedef struct packed {
    logic         load;
    logic         add_req;
    logic         start_req;
    logic         tick;
    logic         mul;
    logic         finish;
    logic         scan_step;
    logic         start_scan;
    logic         emit;
    result_kind_t emit_kind;
  } ars_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       reject;
    logic       dup;
    logic       active;
    logic       timeout_hit;
    logic       pending_nz;
    logic       scan_hit;
    logic       out_free;
  } ars_status_t;

endpackage

// ===== rtl/core/ars_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_ctrl
// Sequencer state machine: decodes each request and steps the datapath.
// ----------------------------------------------------------------------------
module ars_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ars_pkg::ars_status_t status,
  output ars_pkg::ars_cmd_t    cmd
);
  import ars_pkg::*;

  ars_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        case (status.req_type)
          REQ_CHANNEL: begin
            if (status.reject) state_nxt = ST_EMIT_REJ;
            else if (!status.dup && !status.active) state_nxt = ST_EMIT_ST;
          end
          REQ_DONE: begin
            if (status.active) state_nxt = ST_MUL;
          end
          REQ_TICK: begin
            if (status.active && status.timeout_hit) state_nxt = ST_MUL;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_EMIT_REJ,
      ST_EMIT_ST: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      ST_MUL: state_nxt = ST_SUB;
      ST_SUB: state_nxt = ST_EMIT_RD;
      ST_EMIT_RD: begin
        if (status.out_free) state_nxt = status.pending_nz ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (status.scan_hit) state_nxt = ST_EMIT_ST;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.emit_kind = KIND_READING;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DECODE: begin
        case (status.req_type)
          REQ_CHANNEL: begin
            cmd.add_req   = !status.reject && !status.dup;
            cmd.start_req = !status.reject && !status.dup && !status.active;
          end
          REQ_TICK: cmd.tick = status.active;
          default: cmd.tick = 1'b0;
        endcase
      end
      ST_EMIT_REJ: begin
        cmd.emit      = status.out_free;
        cmd.emit_kind = KIND_REJECT;
      end
      ST_EMIT_ST: begin
        cmd.emit      = status.out_free;
        cmd.emit_kind = KIND_START;
      end
      ST_MUL: cmd.mul = 1'b1;
      ST_SUB: cmd.finish = 1'b1;
      ST_EMIT_RD: begin
        cmd.emit      = status.out_free;
        cmd.emit_kind = KIND_READING;
      end
      ST_SCAN: begin
        cmd.start_scan = status.scan_hit;
        cmd.scan_step  = !status.scan_hit;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/ars_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_dp
// Sequencer datapath: request bitmap, timer, code conversion, result register.
// ----------------------------------------------------------------------------
module ars_dp #(
  parameter int CHANNELS = ars_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ars_pkg::ars_cmd_t                cmd,
  output ars_pkg::ars_status_t             status,
  input  logic [ars_pkg::TUSER_W-1:0]      in_tuser,
  input  logic [ars_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             cfg_we,
  input  logic [ars_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ars_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ars_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [ars_pkg::TUSER_W-1:0]      out_tuser,
  output logic                             out_tlast
);
  import ars_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW   = $clog2(CHANNELS + 1);
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  // configuration
  logic        divider_mode_r;
  logic [2:0]  time_select_r;
  logic        mux_present_r;
  logic [15:0] timeout_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divider_mode_r  <= 1'b0;
      time_select_r   <= TIME_SELECT_RST;
      mux_present_r   <= 1'b0;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DIVIDER_MODE:  divider_mode_r  <= cfg_wdata[0];
        CFG_TIME_SELECT:   time_select_r   <= cfg_wdata[2:0];
        CFG_MUX_PRESENT:   mux_present_r   <= cfg_wdata[0];
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured request
  logic [1:0]  type_r;
  logic [7:0]  chan_r;
  logic [15:0] code_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= in_tuser;
      chan_r <= in_tdata[7:0];
      code_r <= in_tdata[23:8];
    end
  end

  // sequencer state
  logic [CHANNELS-1:0] request_bits_r;
  logic [PW-1:0]       pending_r;
  logic                active_r;
  logic [CH_W-1:0]     active_ch_r;
  logic [15:0]         elapsed_r;
  logic [CH_W-1:0]     scan_ptr_r;
  logic [15:0]         elapsed_nxt;
  logic [CH_W-1:0]     req_idx;

  assign req_idx     = chan_r[CH_W-1:0];
  assign elapsed_nxt = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      request_bits_r <= '0;
      pending_r      <= '0;
      active_r       <= 1'b0;
      active_ch_r    <= '0;
      elapsed_r      <= '0;
      scan_ptr_r     <= '0;
    end else begin
      if (cmd.add_req) begin
        request_bits_r[req_idx] <= 1'b1;
        pending_r               <= pending_r + PW'(1);
      end
      if (cmd.start_req) begin
        active_r    <= 1'b1;
        active_ch_r <= req_idx;
        elapsed_r   <= '0;
      end
      if (cmd.tick) elapsed_r <= elapsed_nxt;
      if (cmd.finish) begin
        request_bits_r[active_ch_r] <= 1'b0;
        if (pending_r != '0) pending_r <= pending_r - PW'(1);
        active_r   <= 1'b0;
        scan_ptr_r <= (active_ch_r == LAST_CH) ? '0 : active_ch_r + CH_W'(1);
      end
      if (cmd.scan_step) begin
        scan_ptr_r <= (scan_ptr_r == LAST_CH) ? '0 : scan_ptr_r + CH_W'(1);
      end
      if (cmd.start_scan) begin
        active_r    <= 1'b1;
        active_ch_r <= scan_ptr_r;
        elapsed_r   <= '0;
      end
    end
  end

  // conversion: code*1000, scale by 2^-T, subtract from base, optional /16
  localparam logic signed [READING_W-1:0] ZERO_READING = '0;

  logic [PRODUCT_W-1:0]          product_r;
  logic [PRODUCT_W-1:0]          shifted;
  logic signed [READING_W-1:0]   diff_r, diff_nxt;
  logic signed [READING_W-1:0]   reading_nxt;

  assign shifted  = product_r >> time_select_r;
  assign diff_nxt = CODE_BASE - $signed({2'b00, shifted});

  always_ff @(posedge clk) begin
    if (cmd.mul)    product_r <= PRODUCT_W'(code_r) * PRODUCT_W'(CONV_SCALE);
    if (cmd.finish) diff_r    <= diff_nxt;
  end

  // truncate toward zero on divide
  always_comb begin
    if (code_r == '0)        reading_nxt = OVERLOAD_VALUE;
    else if (divider_mode_r) reading_nxt =
        (diff_r + (diff_r[READING_W-1] ? DIV16_BIAS : ZERO_READING)) >>> 4;
    else                     reading_nxt = diff_r;
  end

  // result register
  logic                 out_valid_r;
  logic [1:0]           kind_r;
  logic [7:0]           och_r;
  logic [READING_W-1:0] reading_r;
  logic                 ovl_r;
  logic                 tmo_r;
  logic [3:0]           cw_r;
  logic                 last_r;
  logic                 out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r    <= cmd.emit_kind;
      och_r     <= (cmd.emit_kind == KIND_REJECT) ? chan_r : 8'(active_ch_r);
      reading_r <= '0;
      ovl_r     <= 1'b0;
      tmo_r     <= 1'b0;
      cw_r      <= '0;
      last_r    <= 1'b1;
      case (cmd.emit_kind)
        KIND_READING: begin
          reading_r <= reading_nxt;
          ovl_r     <= (code_r == '0);
          tmo_r     <= (type_r == REQ_TICK);
          last_r    <= (pending_r == '0);
        end
        KIND_START: cw_r <= {divider_mode_r, time_select_r};
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {6'd0, cw_r, tmo_r, ovl_r, reading_r, och_r};

  // status
  always_comb begin
    status             = '0;
    status.req_type    = type_r;
    status.reject      = (chan_r != 8'd0 && !mux_present_r) || (chan_r >= 8'(CHANNELS));
    status.dup         = request_bits_r[req_idx];
    status.active      = active_r;
    status.timeout_hit = (elapsed_nxt >= timeout_ticks_r);
    status.pending_nz  = (pending_r != '0);
    status.scan_hit    = request_bits_r[scan_ptr_r];
    status.out_free    = out_free;
  end

endmodule

// ===== rtl/core/adc_request_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_request_sequencer_unit
// Multiplexed ADC measurement sequencer with round-robin channel scheduling.
// ----------------------------------------------------------------------------
// Order: a request is captured, then decoded; a reject or start result goes to
//   the result register once it has room. A done or timeout tick that ends the
//   active conversion runs the multiply and subtract steps, then emits the reading
//   and, while requests are pending, scans round-robin for the next start command,
//   one channel per cycle. Requests are taken only while the sequencer is idle.
// Reset: synchronous active-low rst_n clears the bitmap, counters and result
//   valid flag and restores the configuration defaults.
module adc_request_sequencer_unit #(
  parameter int CHANNELS = ars_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ars_pkg::IN_DATA_W-1:0]  in_tdata,   // channel[7:0], adc_code[23:8]
  input  logic [ars_pkg::TUSER_W-1:0]    in_tuser,   // req_type[1:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ars_pkg::OUT_DATA_W-1:0] out_tdata,  // out_channel[7:0], reading[35:8],
                                                     // overload[36], timed_out[37],
                                                     // control_word[41:38], zero[47:42]
  output logic [ars_pkg::TUSER_W-1:0]    out_tuser,  // result_kind[1:0]
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [ars_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ars_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ars_pkg::*;

  ars_cmd_t    cmd;
  ars_status_t status;

  ars_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ars_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // a running conversion always has its own request pending
  a_active_pending: assert property (@(posedge clk) disable iff (!rst_n)
    status.active |-> status.pending_nz)
    else $error("active conversion with no pending request");

  // the scan only runs while some request is left
  a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step || cmd.start_scan) |-> status.pending_nz)
    else $error("channel scan with empty bitmap");

  // one request at a time
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while previous one in progress");

  // results only go out when the register has room
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result written over a pending result");

endmodule
